### rtl/dtq_pkg.sv
// dtq_pkg: shared types and codes for the deadline timer queue
// no dependencies; imported by dtq_cell, dtq_chain and deadline_timer_queue_top
`timescale 1ns / 1ps

package dtq_pkg;

    localparam int TimeW  = 48;
    localparam int DelayW = 32;
    localparam logic [TimeW-1:0] TIME_MAX = {TimeW{1'b1}};
    localparam logic [5:0] BATCH_RESET = 6'd10;

    localparam logic [1:0] MODE_SET    = 2'd0;
    localparam logic [1:0] MODE_CANCEL = 2'd1;
    localparam logic [1:0] MODE_UPDATE = 2'd2;
    localparam logic [1:0] MODE_SIGNAL = 2'd3;

    localparam logic [2:0] EV_ARMED     = 3'd0;
    localparam logic [2:0] EV_REJECTED  = 3'd1;
    localparam logic [2:0] EV_CANCELLED = 3'd2;
    localparam logic [2:0] EV_UPDATED   = 3'd3;
    localparam logic [2:0] EV_FIRED     = 3'd4;
    localparam logic [2:0] EV_DONE      = 3'd5;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_KILL,
        CELL_POP
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic [TimeW-1:0] key;
        logic             kind;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_UPD,
        ST_FIRE,
        ST_DRAIN
    } t_state;

endpackage

### rtl/dtq_cell.sv
// dtq_cell: one entry of the sorted timer chain (deadline, slot, kind)
// depends on dtq_pkg; instantiated by dtq_chain
`timescale 1ns / 1ps

module dtq_cell import dtq_pkg::*; #(
    parameter int SW = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  logic [SW-1:0]    i_cmd_handle,
    input  logic             i_head,
    input  logic             i_left_v,
    input  logic             i_left_g,
    input  logic [TimeW-1:0] i_left_dl,
    input  logic [SW-1:0]    i_left_h,
    input  logic             i_left_k,
    input  logic             i_right_v,
    input  logic [TimeW-1:0] i_right_dl,
    input  logic [SW-1:0]    i_right_h,
    input  logic             i_right_k,
    output logic             o_v,
    output logic             o_g,
    output logic [TimeW-1:0] o_dl,
    output logic [SW-1:0]    o_h,
    output logic             o_k
);

    logic             r_v, n_v;
    logic [TimeW-1:0] r_dl, n_dl;
    logic [SW-1:0]    r_h, n_h;
    logic             r_k, n_k;
    logic             g;

    assign g = r_v && (r_dl <= i_ctl.key);

    always_comb begin
        n_v  = r_v;
        n_dl = r_dl;
        n_h  = r_h;
        n_k  = r_k;
        unique case (i_ctl.op)
            CELL_HOLD: begin
                if (!r_v) begin
                    n_v  = i_right_v;
                    n_dl = i_right_dl;
                    n_h  = i_right_h;
                    n_k  = i_right_k;
                end else if (!i_left_v) begin
                    n_v = 1'b0;
                end
            end
            CELL_INS: begin
                if (!g) begin
                    if (i_left_g) begin
                        n_v  = 1'b1;
                        n_dl = i_ctl.key;
                        n_h  = i_cmd_handle;
                        n_k  = i_ctl.kind;
                    end else begin
                        n_v  = i_left_v;
                        n_dl = i_left_dl;
                        n_h  = i_left_h;
                        n_k  = i_left_k;
                    end
                end
            end
            CELL_KILL: begin
                if (r_v && r_h == i_cmd_handle) begin
                    n_v = 1'b0;
                end
            end
            CELL_POP: begin
                if (i_head) begin
                    n_v = 1'b0;
                end
            end
            default: begin
                n_v = r_v;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= n_v;
        end
        r_dl <= n_dl;
        r_h  <= n_h;
        r_k  <= n_k;
    end

    assign o_v  = r_v;
    assign o_g  = g;
    assign o_dl = r_dl;
    assign o_h  = r_h;
    assign o_k  = r_k;

endmodule

### rtl/dtq_chain.sv
// dtq_chain: row of dtq_cell entries kept sorted by deadline, with head view
// depends on dtq_pkg and dtq_cell; instantiated by deadline_timer_queue_top
`timescale 1ns / 1ps

module dtq_chain import dtq_pkg::*; #(
    parameter int N  = 64,
    parameter int SW = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  logic [SW-1:0]    i_cmd_handle,
    output logic             o_head_v,
    output logic [TimeW-1:0] o_head_dl,
    output logic [SW-1:0]    o_head_h,
    output logic             o_head_k,
    output logic             o_packed
);

    logic [N-1:0]     v;
    logic [N-1:0]     g;
    logic [TimeW-1:0] dl [N];
    logic [SW-1:0]    h  [N];
    logic [N-1:0]     k;
    logic [N-2:0]     gap;

    for (genvar i = 0; i < N; i++) begin : g_cell
        logic             lv, lg, lk, rv, rk;
        logic [TimeW-1:0] ldl, rdl;
        logic [SW-1:0]    lh, rh;
        if (i == 0) begin : g_first
            assign lv  = 1'b1;
            assign lg  = 1'b1;
            assign ldl = '0;
            assign lh  = '0;
            assign lk  = 1'b0;
        end else begin : g_mid
            assign lv  = v[i-1];
            assign lg  = g[i-1];
            assign ldl = dl[i-1];
            assign lh  = h[i-1];
            assign lk  = k[i-1];
        end
        if (i == N-1) begin : g_last
            assign rv  = 1'b0;
            assign rdl = '0;
            assign rh  = '0;
            assign rk  = 1'b0;
        end else begin : g_inner
            assign rv  = v[i+1];
            assign rdl = dl[i+1];
            assign rh  = h[i+1];
            assign rk  = k[i+1];
            assign gap[i] = ~v[i] & v[i+1];
        end
        dtq_cell #(.SW(SW)) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (i_ctl),
            .i_cmd_handle (i_cmd_handle),
            .i_head       (i == 0),
            .i_left_v     (lv),
            .i_left_g     (lg),
            .i_left_dl    (ldl),
            .i_left_h     (lh),
            .i_left_k     (lk),
            .i_right_v    (rv),
            .i_right_dl   (rdl),
            .i_right_h    (rh),
            .i_right_k    (rk),
            .o_v          (v[i]),
            .o_g          (g[i]),
            .o_dl         (dl[i]),
            .o_h          (h[i]),
            .o_k          (k[i])
        );
    end

    assign o_head_v  = v[0];
    assign o_head_dl = dl[0];
    assign o_head_h  = h[0];
    assign o_head_k  = k[0];
    assign o_packed  = ~|gap;

endmodule

### rtl/deadline_timer_queue_top.sv
// deadline_timer_queue_top: timer table on a sorted cell chain with command port
// depends on dtq_pkg and dtq_chain
`timescale 1ns / 1ps

// Set and cancel give one result, registered from the execute state; a valid update
// gives it from the update state once the chain has closed the gap left by the removed
// entry. Busy stays high after a cancel, an update or a fire until the chain has closed
// its gaps, and after an arm while the free-slot scanner steps to the next free slot,
// one slot a cycle. A signal pops due timers one at a time from the chain head into a
// local buffer, then streams the fired results one a cycle and the closing result,
// since every result carries the totals after the whole command. Results appear on
// o_strobe for one cycle and cannot be stalled. The config port is always ready.

module deadline_timer_queue_top import dtq_pkg::*; #(
    parameter int TIMER_SLOTS = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               i_mode,
    input  logic [TimeW-1:0]         i_now_ms,
    input  logic signed [DelayW-1:0] i_delay_ms,
    input  logic                     i_timer_kind,
    input  logic [5:0]               i_handle,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [5:0]               i_cfg_data,
    output logic                     o_strobe,
    output logic [2:0]               o_event_res,
    output logic [5:0]               o_out_handle,
    output logic                     o_fired_kind,
    output logic                     o_bad_handle,
    output logic [5:0]               o_fired_count,
    output logic [6:0]               o_active_count,
    output logic [31:0]              o_created_total,
    output logic [31:0]              o_cancelled_total,
    output logic [31:0]              o_triggered_total,
    output logic                     o_last
);

    localparam int SW = $clog2(TIMER_SLOTS);
    localparam int CW = $clog2(TIMER_SLOTS + 1);
    localparam logic [CW-1:0] FULL = CW'(TIMER_SLOTS);

    t_state r_state, n_state;
    logic [1:0]               r_mode;
    logic [TimeW-1:0]         r_now;
    logic signed [DelayW-1:0] r_delay;
    logic                     r_kind;
    logic [5:0]               r_handle;
    logic [TIMER_SLOTS-1:0]   r_used, n_used;
    logic [SW-1:0]            r_ptr, n_ptr;
    logic                     r_ok, n_ok;
    logic [CW-1:0]            r_pend, n_pend;
    logic [31:0]              r_armed, n_armed, r_canc, n_canc, r_fire, n_fire;
    logic [5:0]               r_limit;
    logic [5:0]               r_fired, n_fired, r_rd, n_rd;
    logic                     r_rd_v, n_rd_v;
    logic [6:0]               r_rd_data;
    logic [6:0]               r_fifo [64];
    logic                     r_kind_mem [TIMER_SLOTS];
    logic                     r_kind_rd;

    logic                     r_strb, n_strb;
    logic [2:0]               r_ev, n_ev;
    logic [5:0]               r_oh, n_oh;
    logic                     r_fk, n_fk, r_bad, n_bad, r_last, n_last;
    logic [5:0]               r_fc, n_fc;

    t_cell_ctl                ctl;
    logic [SW-1:0]            cmd_handle;
    logic                     head_v, head_k, packed_ok;
    logic [TimeW-1:0]         head_dl;
    logic [SW-1:0]            head_h;

    logic [SW-1:0]            h_idx;
    logic                     h_bad, delay_pos, accept;
    logic signed [TimeW+1:0]  sum;
    logic [TimeW-1:0]         sat_dl;
    logic                     free_en, arm_en, fifo_we;
    logic [SW-1:0]            free_idx;

    assign h_idx     = SW'(r_handle);
    assign h_bad     = (32'(r_handle) >= TIMER_SLOTS) || !r_used[h_idx];
    assign delay_pos = (r_delay != '0) && !r_delay[DelayW-1];
    assign sum       = $signed({2'b00, r_now}) + (TimeW+2)'(r_delay);

    always_comb begin
        if (sum < 0) begin
            sat_dl = '0;
        end else if (sum > $signed({2'b00, TIME_MAX})) begin
            sat_dl = TIME_MAX;
        end else begin
            sat_dl = sum[TimeW-1:0];
        end
    end

    assign busy   = (r_state != ST_IDLE) || !packed_ok || (!r_ok && r_pend != FULL);
    assign accept = start && !busy;

    dtq_chain #(.N(TIMER_SLOTS), .SW(SW)) u_chain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_cmd_handle (cmd_handle),
        .o_head_v     (head_v),
        .o_head_dl    (head_dl),
        .o_head_h     (head_h),
        .o_head_k     (head_k),
        .o_packed     (packed_ok)
    );

    always_comb begin
        n_state    = r_state;
        n_used     = r_used;
        n_pend     = r_pend;
        n_armed    = r_armed;
        n_canc     = r_canc;
        n_fire     = r_fire;
        n_fired    = r_fired;
        n_rd       = r_rd;
        n_rd_v     = 1'b0;
        n_strb     = 1'b0;
        n_ev       = EV_DONE;
        n_oh       = '0;
        n_fk       = 1'b0;
        n_bad      = 1'b0;
        n_fc       = '0;
        n_last     = 1'b0;
        ctl.op     = CELL_HOLD;
        ctl.key    = sat_dl;
        ctl.kind   = r_kind;
        cmd_handle = h_idx;
        free_en    = 1'b0;
        free_idx   = h_idx;
        arm_en     = 1'b0;
        fifo_we    = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
                unique case (r_mode)
                    MODE_SET: begin
                        n_strb = 1'b1;
                        n_last = 1'b1;
                        if (!delay_pos || r_pend == FULL) begin
                            n_ev = EV_REJECTED;
                        end else begin
                            ctl.op     = CELL_INS;
                            cmd_handle = r_ptr;
                            arm_en     = 1'b1;
                            n_used[r_ptr] = 1'b1;
                            n_pend  = r_pend + CW'(1);
                            n_armed = r_armed + 32'd1;
                            n_ev    = EV_ARMED;
                            n_oh    = 6'(r_ptr);
                        end
                    end
                    MODE_CANCEL, MODE_UPDATE: begin
                        if (h_bad) begin
                            n_strb = 1'b1;
                            n_last = 1'b1;
                            n_bad  = 1'b1;
                            n_ev   = EV_DONE;
                        end else if (r_mode == MODE_CANCEL) begin
                            ctl.op  = CELL_KILL;
                            free_en = 1'b1;
                            n_used[h_idx] = 1'b0;
                            n_pend = r_pend - CW'(1);
                            n_canc = r_canc + 32'd1;
                            n_strb = 1'b1;
                            n_last = 1'b1;
                            n_ev   = EV_CANCELLED;
                            n_oh   = r_handle;
                        end else begin
                            ctl.op  = CELL_KILL;
                            n_state = ST_UPD;
                        end
                    end
                    MODE_SIGNAL: begin
                        n_fired = '0;
                        n_rd    = '0;
                        n_state = ST_FIRE;
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_UPD: begin
                if (packed_ok) begin
                    ctl.op   = CELL_INS;
                    ctl.kind = r_kind_rd;
                    n_strb   = 1'b1;
                    n_last   = 1'b1;
                    n_ev     = EV_UPDATED;
                    n_oh     = r_handle;
                    n_state  = ST_IDLE;
                end
            end
            ST_FIRE: begin
                priority if (r_fired == r_limit) begin
                    n_state = ST_DRAIN;
                end else if (head_v) begin
                    if (head_dl <= r_now) begin
                        ctl.op   = CELL_POP;
                        free_en  = 1'b1;
                        free_idx = head_h;
                        fifo_we  = 1'b1;
                        n_used[head_h] = 1'b0;
                        n_pend  = r_pend - CW'(1);
                        n_fire  = r_fire + 32'd1;
                        n_fired = r_fired + 6'd1;
                    end else begin
                        n_state = ST_DRAIN;
                    end
                end else if (packed_ok) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_state = ST_FIRE;
                end
            end
            ST_DRAIN: begin
                if (r_rd_v) begin
                    n_strb = 1'b1;
                    n_ev   = EV_FIRED;
                    n_oh   = r_rd_data[6:1];
                    n_fk   = r_rd_data[0];
                end
                if (r_rd != r_fired) begin
                    n_rd_v = 1'b1;
                    n_rd   = r_rd + 6'd1;
                end else if (!r_rd_v) begin
                    n_strb  = 1'b1;
                    n_last  = 1'b1;
                    n_ev    = EV_DONE;
                    n_fc    = r_fired;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // lowest free slot tracker
    always_comb begin
        n_ptr = r_ptr;
        n_ok  = r_ok;
        if (free_en && free_idx <= r_ptr) begin
            n_ptr = free_idx;
            n_ok  = 1'b1;
        end else if (arm_en) begin
            n_ok = 1'b0;
        end else if (!r_ok && r_pend != FULL) begin
            if (r_used[r_ptr]) begin
                n_ptr = r_ptr + SW'(1);
            end else begin
                n_ok = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_used  <= '0;
            r_ptr   <= '0;
            r_ok    <= 1'b0;
            r_pend  <= '0;
            r_armed <= '0;
            r_canc  <= '0;
            r_fire  <= '0;
            r_limit <= BATCH_RESET;
            r_fired <= '0;
            r_rd    <= '0;
            r_rd_v  <= 1'b0;
            r_strb  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_ptr   <= n_ptr;
            r_ok    <= n_ok;
            r_pend  <= n_pend;
            r_armed <= n_armed;
            r_canc  <= n_canc;
            r_fire  <= n_fire;
            r_fired <= n_fired;
            r_rd    <= n_rd;
            r_rd_v  <= n_rd_v;
            r_strb  <= n_strb;
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode   <= i_mode;
            r_now    <= i_now_ms;
            r_delay  <= i_delay_ms;
            r_kind   <= i_timer_kind;
            r_handle <= i_handle;
        end
        r_ev   <= n_ev;
        r_oh   <= n_oh;
        r_fk   <= n_fk;
        r_bad  <= n_bad;
        r_fc   <= n_fc;
        r_last <= n_last;
    end

    // fired beat buffer
    always_ff @(posedge i_clk) begin
        if (fifo_we) begin
            r_fifo[r_fired] <= {6'(head_h), head_k};
        end
        r_rd_data <= r_fifo[r_rd];
    end

    // kind per slot, read back for update
    always_ff @(posedge i_clk) begin
        if (arm_en) begin
            r_kind_mem[r_ptr] <= r_kind;
        end
        r_kind_rd <= r_kind_mem[h_idx];
    end

    assign o_cfg_ready       = 1'b1;
    assign o_strobe          = r_strb;
    assign o_event_res       = r_ev;
    assign o_out_handle      = r_oh;
    assign o_fired_kind      = r_fk;
    assign o_bad_handle      = r_bad;
    assign o_fired_count     = r_fc;
    assign o_last            = r_last;
    assign o_active_count    = 7'(r_pend);
    assign o_created_total   = r_armed;
    assign o_cancelled_total = r_canc;
    assign o_triggered_total = r_fire;

endmodule
